// ===== rtl/sdpe_pkg.sv =====
// Shared constants, coefficient table and sine lookup for the sliding DFT phasor estimator.
package sdpe_pkg;

  localparam int WINDOW_LEN_DEF = 200;
  localparam int DATA_W         = 32;
  localparam int COEF_W         = 25;
  localparam int COEF_SHIFT     = 30;
  localparam int TABLE_PERIOD   = 200;
  localparam int TABLE_QUARTER  = 50;
  localparam int PHASE_W        = 8;

  typedef logic [22:0] quarter_t;
  typedef logic signed [COEF_W-1:0] coef_t;

  // sqrt(2)/200 * sin(2*pi*m/200) in Q30, truncated, m = 0..50
  localparam quarter_t QUARTER_WAVE [0:TABLE_QUARTER] = '{
    23'd0,       23'd238486,  23'd476737,  23'd714517,  23'd951592,
    23'd1187728, 23'd1422692, 23'd1656252, 23'd1888178, 23'd2118240,
    23'd2346211, 23'd2571868, 23'd2794986, 23'd3015345, 23'd3232729,
    23'd3446923, 23'd3657715, 23'd3864897, 23'd4068265, 23'd4267618,
    23'd4462760, 23'd4653497, 23'd4839642, 23'd5021011, 23'd5197424,
    23'd5368709, 23'd5534695, 23'd5695219, 23'd5850122, 23'd5999252,
    23'd6142462, 23'd6279610, 23'd6410560, 23'd6535184, 23'd6653359,
    23'd6764968, 23'd6869900, 23'd6968053, 23'd7059329, 23'd7143638,
    23'd7220897, 23'd7291031, 23'd7353968, 23'd7409649, 23'd7458017,
    23'd7499024, 23'd7532632, 23'd7558805, 23'd7577519, 23'd7588754,
    23'd7592501
  };

  // Signed sine at a table phase below two table periods
  function automatic coef_t sine_at(input logic [PHASE_W:0] p_in);
    logic [PHASE_W:0] p;
    logic [PHASE_W:0] idx;
    logic             neg;
    coef_t            mag;
    p = (p_in >= (PHASE_W+1)'(TABLE_PERIOD)) ? p_in - (PHASE_W+1)'(TABLE_PERIOD) : p_in;
    if (p <= (PHASE_W+1)'(TABLE_QUARTER)) begin
      idx = p;
      neg = 1'b0;
    end else if (p <= (PHASE_W+1)'(2*TABLE_QUARTER)) begin
      idx = (PHASE_W+1)'(2*TABLE_QUARTER) - p;
      neg = 1'b0;
    end else if (p <= (PHASE_W+1)'(3*TABLE_QUARTER)) begin
      idx = p - (PHASE_W+1)'(2*TABLE_QUARTER);
      neg = 1'b1;
    end else begin
      idx = (PHASE_W+1)'(TABLE_PERIOD) - p;
      neg = 1'b1;
    end
    mag = coef_t'({1'b0, QUARTER_WAVE[idx[5:0]]});
    return neg ? -mag : mag;
  endfunction

endpackage

// ===== rtl/sdpe_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
module sdpe_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 200
) (
  input  logic                            clk,
  input  logic                            we,
  input  logic [$clog2(DEPTH)-1:0]        waddr,
  input  logic [WIDTH-1:0]                wdata,
  input  logic                            re,
  input  logic [$clog2(DEPTH)-1:0]        raddr,
  output logic [WIDTH-1:0]                rdata
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/sliding_dft_phasor_estimator_unit.sv =====
// Sliding full-cycle DFT phasor estimator: circular sample memory and one MAC pair shared by all taps.
// After a sample transfer, result_valid rises once the last tap is accumulated and the output register is free.
// A new sample is taken only after the previous result is loaded; each tap takes one read of the
// sample memory and one pass through the shared real/imaginary multiplier pair.
// A finished result waits in an output register while the next sample is taken.
// Reset clears control and the fill count; memory slots never written read as zero.
module sliding_dft_phasor_estimator_unit #(
  parameter int WINDOW_LEN = sdpe_pkg::WINDOW_LEN_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               sample_valid,
  output logic                               sample_ready,
  input  logic signed [sdpe_pkg::DATA_W-1:0] sample,
  output logic                               result_valid,
  input  logic                               result_ready,
  output logic signed [sdpe_pkg::DATA_W-1:0] phasor_real,
  output logic signed [sdpe_pkg::DATA_W-1:0] phasor_imag
);

  localparam int AW      = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
  localparam int CW      = $clog2(WINDOW_LEN + 1);
  localparam int DW      = sdpe_pkg::DATA_W;
  localparam int PW      = sdpe_pkg::DATA_W + sdpe_pkg::COEF_W;
  localparam int PHW     = sdpe_pkg::PHASE_W;
  localparam int PH_STEP = sdpe_pkg::TABLE_PERIOD / WINDOW_LEN;
  localparam int PH_REM  = sdpe_pkg::TABLE_PERIOD % WINDOW_LEN;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_RUN   = 3'b010,
    ST_DRAIN = 3'b100
  } state_t;

  state_t                  state;
  logic [AW-1:0]           wp;
  logic [CW-1:0]           fill;
  logic [AW-1:0]           raddr;
  logic [AW-1:0]           tap;
  logic [PHW-1:0]          ph;
  logic [AW-1:0]           rem;
  logic                    s1_v;
  logic                    s1_ok;
  logic [PHW-1:0]          s1_ph;
  logic                    s2_v;
  logic [DW-1:0]           p_re;
  logic [DW-1:0]           p_im;
  logic [DW-1:0]           acc_re;
  logic [DW-1:0]           acc_im;
  logic [DW-1:0]           rdata;

  logic                    in_xfer;
  logic                    load;
  logic                    slot_ok;
  logic [AW:0]             rem_sum;
  logic [AW:0]             rem_adj;
  logic                    carry;
  logic [AW-1:0]           rem_next;
  logic [PHW:0]            ph_sum;
  logic [PHW:0]            ph_adj;
  logic [PHW-1:0]          ph_next;
  logic [DW-1:0]           s1_samp;
  sdpe_pkg::coef_t         coef_re;
  sdpe_pkg::coef_t         coef_im;
  logic signed [PW-1:0]    prod_re;
  logic signed [PW-1:0]    prod_im;

  function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] a);
    return (a == AW'(WINDOW_LEN - 1)) ? '0 : a + 1'b1;
  endfunction

  assign sample_ready = (state == ST_IDLE);
  assign in_xfer      = sample_valid && sample_ready;
  assign load         = (state == ST_DRAIN) && !s1_v && !s2_v &&
                        (!result_valid || result_ready);

  // Sample memory: write on transfer, read one tap per cycle while running
  sdpe_ram #(
    .WIDTH (DW),
    .DEPTH (WINDOW_LEN)
  ) u_window (
    .clk   (clk),
    .we    (in_xfer),
    .waddr (wp),
    .wdata (sample),
    .re    (state == ST_RUN),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Slot holds a written sample once enough samples have arrived
  assign slot_ok = ((CW+1)'(tap) + (CW+1)'(fill)) >= (CW+1)'(WINDOW_LEN);

  // Advance table phase floor((k+1)*period/N) by quotient and remainder steps
  always_comb begin
    rem_sum  = {1'b0, rem} + (AW+1)'(PH_REM);
    rem_adj  = rem_sum - (AW+1)'(WINDOW_LEN);
    carry    = (rem_sum >= (AW+1)'(WINDOW_LEN));
    rem_next = carry ? rem_adj[AW-1:0] : rem_sum[AW-1:0];
    ph_sum   = {1'b0, ph} + (PHW+1)'(PH_STEP) + (PHW+1)'(carry);
    ph_adj   = ph_sum - (PHW+1)'(sdpe_pkg::TABLE_PERIOD);
    ph_next  = (ph_sum >= (PHW+1)'(sdpe_pkg::TABLE_PERIOD)) ? ph_adj[PHW-1:0] :
                                                               ph_sum[PHW-1:0];
  end

  // Coefficients and products for the tap whose sample just came out of memory
  always_comb begin
    s1_samp = s1_ok ? rdata : '0;
    coef_re = -sdpe_pkg::sine_at({1'b0, s1_ph});
    coef_im = sdpe_pkg::sine_at({1'b0, s1_ph} + (PHW+1)'(sdpe_pkg::TABLE_QUARTER));
    prod_re = $signed({{(PW-DW){s1_samp[DW-1]}}, s1_samp}) *
              $signed({{DW{coef_re[sdpe_pkg::COEF_W-1]}}, coef_re});
    prod_im = $signed({{(PW-DW){s1_samp[DW-1]}}, s1_samp}) *
              $signed({{DW{coef_im[sdpe_pkg::COEF_W-1]}}, coef_im});
  end

  // Sequencer and pipeline control
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      wp           <= '0;
      fill         <= '0;
      s1_v         <= 1'b0;
      s2_v         <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      s1_v <= (state == ST_RUN);
      s2_v <= s1_v;
      case (state)
        ST_IDLE: begin
          if (in_xfer) begin
            wp    <= wrap_inc(wp);
            fill  <= (fill == CW'(WINDOW_LEN)) ? fill : fill + 1'b1;
            state <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (tap == AW'(WINDOW_LEN - 1)) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (load) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
      if (load) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  // Tap address, index and phase walk
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      raddr <= wrap_inc(wp);
      tap   <= '0;
      ph    <= PHW'(PH_STEP);
      rem   <= AW'(PH_REM);
    end else if (state == ST_RUN) begin
      raddr <= wrap_inc(raddr);
      tap   <= tap + 1'b1;
      ph    <= ph_next;
      rem   <= rem_next;
    end
  end

  // Hold per-tap data alongside the memory read
  always_ff @(posedge clk) begin
    s1_ok <= slot_ok;
    s1_ph <= ph;
  end

  // Register the scaled products
  always_ff @(posedge clk) begin
    p_re <= DW'(signed'(prod_re[PW-1:sdpe_pkg::COEF_SHIFT]));
    p_im <= DW'(signed'(prod_im[PW-1:sdpe_pkg::COEF_SHIFT]));
  end

  // Accumulate with wrap; clear on a new sample
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      acc_re <= '0;
      acc_im <= '0;
    end else if (s2_v) begin
      acc_re <= acc_re + p_re;
      acc_im <= acc_im + p_im;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (load) begin
      phasor_real <= acc_re;
      phasor_imag <= acc_im;
    end
  end

`ifndef SYNTHESIS
  a_pipe_busy: assert property (@(posedge clk) disable iff (rst)
    (s1_v || s2_v) |-> (state != ST_IDLE))
    else $error("tap pipeline active while idle");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= CW'(WINDOW_LEN))
    else $error("fill count beyond window length");

  a_start_run: assert property (@(posedge clk) disable iff (rst)
    in_xfer |=> (state == ST_RUN) && (tap == '0))
    else $error("sample transfer did not start a tap walk");

  a_load_valid: assert property (@(posedge clk) disable iff (rst)
    load |=> result_valid)
    else $error("result load lost");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result_ready) |-> !load)
    else $error("pending result overwritten");
`endif

endmodule

// ===== test/phasor_checker.sv =====
// Result checker for the sliding DFT phasor estimator: predicts each phasor and compares it.
module phasor_checker #(
  parameter int WIN_LEN = 200
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               sample_valid,
  input  logic                               sample_ready,
  input  logic signed [sdpe_pkg::DATA_W-1:0] sample,
  input  logic                               result_valid,
  input  logic                               result_ready,
  input  logic signed [sdpe_pkg::DATA_W-1:0] phasor_real,
  input  logic signed [sdpe_pkg::DATA_W-1:0] phasor_imag,
  output int                                 fail_count,
  output int                                 pending,
  output int                                 results_checked
);

  localparam int SINE_PERIOD  = 200;
  localparam int SINE_QUARTER = 50;
  localparam int FRAC_SHIFT   = 30;

  typedef struct packed {
    logic [sdpe_pkg::DATA_W-1:0] re;
    logic [sdpe_pkg::DATA_W-1:0] im;
  } phasor_pair_t;

  // sqrt(2)/200 * sin(2*pi*m/200) in Q30, truncated toward zero, m = 0..50
  localparam longint QUARTER_SINE [0:SINE_QUARTER] = '{
    0, 238486, 476737, 714517, 951592, 1187728, 1422692,
    1656252, 1888178, 2118240, 2346211, 2571868, 2794986,
    3015345, 3232729, 3446923, 3657715, 3864897, 4068265,
    4267618, 4462760, 4653497, 4839642, 5021011, 5197424,
    5368709, 5534695, 5695219, 5850122, 5999252, 6142462,
    6279610, 6410560, 6535184, 6653359, 6764968, 6869900,
    6968053, 7059329, 7143638, 7220897, 7291031, 7353968,
    7409649, 7458017, 7499024, 7532632, 7558805, 7577519,
    7588754, 7592501
  };

  logic signed [sdpe_pkg::DATA_W-1:0] tap_window [WIN_LEN];
  phasor_pair_t                       expected_phasors [$];

  initial begin
    fail_count      = 0;
    results_checked = 0;
  end

  // Unfold the quarter wave into a full signed period
  function automatic longint sine_of(input int unsigned phase);
    int unsigned p;
    p = phase % SINE_PERIOD;
    if (p <= SINE_QUARTER) return QUARTER_SINE[p];
    if (p <= 2 * SINE_QUARTER) return QUARTER_SINE[2 * SINE_QUARTER - p];
    if (p <= 3 * SINE_QUARTER) return -QUARTER_SINE[p - 2 * SINE_QUARTER];
    return -QUARTER_SINE[SINE_PERIOD - p];
  endfunction

  // Shift the sample into the window and sum the weighted taps with 32-bit wrap
  function automatic phasor_pair_t compute_phasor(
      input logic signed [sdpe_pkg::DATA_W-1:0] smp);
    phasor_pair_t acc;
    longint       s;
    longint       p_re;
    longint       p_im;
    int unsigned  phase;
    acc = '0;
    for (int k = 0; k < WIN_LEN - 1; k++) tap_window[k] = tap_window[k + 1];
    tap_window[WIN_LEN - 1] = smp;
    for (int k = 0; k < WIN_LEN; k++) begin
      phase  = ((k + 1) * SINE_PERIOD) / WIN_LEN;
      s      = longint'(tap_window[k]);
      p_re   = (-sine_of(phase) * s) >>> FRAC_SHIFT;
      p_im   = (sine_of(phase + SINE_QUARTER) * s) >>> FRAC_SHIFT;
      acc.re = acc.re + p_re[sdpe_pkg::DATA_W-1:0];
      acc.im = acc.im + p_im[sdpe_pkg::DATA_W-1:0];
    end
    return acc;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("[%0t] %s: got %h, expected %h", $time, what, got, want);
    fail_count++;
  endtask

  // Check the result transfer before taking the new sample: it belongs to an older one
  always @(posedge clk) begin : watch
    phasor_pair_t want;
    if (rst) begin
      foreach (tap_window[i]) tap_window[i] = '0;
      expected_phasors.delete();
    end else begin
      if (result_valid && result_ready) begin
        if (expected_phasors.size() == 0) begin
          report_mismatch("result with no sample pending", phasor_real, '0);
        end else begin
          want = expected_phasors.pop_front();
          if (phasor_real !== want.re) report_mismatch("phasor_real", phasor_real, want.re);
          if (phasor_imag !== want.im) report_mismatch("phasor_imag", phasor_imag, want.im);
          results_checked++;
        end
      end
      if (sample_valid && sample_ready) expected_phasors.push_back(compute_phasor(sample));
    end
    pending <= expected_phasors.size();
  end

endmodule

// ===== test/testbench.sv =====
// Testbench top for the sliding DFT phasor estimator: clock, reset, stimulus and verdict.
module testbench;

  localparam int WIN_LEN      = 200;
  localparam int CLK_PERIOD   = 20;
  localparam int LIMIT_CYCLES = 3_000_000;
  localparam int RANDOM_ITEMS = 1300;
  localparam int DRAIN_EVERY  = 350;
  localparam int HOLD_START   = 60_000;
  localparam int HOLD_CYCLES  = 4 * WIN_LEN;

  typedef enum int {
    MODE_FULL,
    MODE_SMALL,
    MODE_EXTREME,
    MODE_SQUARE,
    MODE_RAMP
  } sample_mode_t;

  // Full-scale corners, unit steps, Q20 one, bit patterns, runs of the extremes, then two small values
  localparam logic signed [31:0] DIRECTED [21] = '{
    32'sh00000000, 32'sh00000001, 32'shffffffff, 32'sh7fffffff, 32'sh80000000,
    32'sh7fffffff, 32'sh80000000, 32'shfffffffe, 32'shfffffffd, 32'sh00100000,
    32'shfff00000, 32'sh55555555, 32'shaaaaaaaa, 32'sh80000000, 32'sh80000000,
    32'sh80000000, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh00003039,
    32'shffff2bcf
  };

  logic                               clk;
  logic                               rst;
  logic                               sample_valid;
  logic                               sample_ready;
  logic signed [sdpe_pkg::DATA_W-1:0] sample;
  logic                               result_valid;
  logic                               result_ready;
  logic signed [sdpe_pkg::DATA_W-1:0] phasor_real;
  logic signed [sdpe_pkg::DATA_W-1:0] phasor_imag;
  int                                 fail_count;
  int                                 pending;
  int                                 results_checked;
  int                                 samples_sent;
  logic                               rx_holding;

  // Start low so the first rising edge comes after reset is driven
  always begin
    clk = 1'b0;
    #(CLK_PERIOD / 2);
    clk = 1'b1;
    #(CLK_PERIOD / 2);
  end

  sliding_dft_phasor_estimator_unit #(
    .WINDOW_LEN(WIN_LEN)
  ) u_top (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .sample       (sample),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .phasor_real  (phasor_real),
    .phasor_imag  (phasor_imag)
  );

  phasor_checker #(
    .WIN_LEN(WIN_LEN)
  ) u_checker (
    .clk             (clk),
    .rst             (rst),
    .sample_valid    (sample_valid),
    .sample_ready    (sample_ready),
    .sample          (sample),
    .result_valid    (result_valid),
    .result_ready    (result_ready),
    .phasor_real     (phasor_real),
    .phasor_imag     (phasor_imag),
    .fail_count      (fail_count),
    .pending         (pending),
    .results_checked (results_checked)
  );

  // Offer one sample and hold it until the transfer
  task automatic send_sample(input logic signed [31:0] value);
    sample       <= value;
    sample_valid <= 1'b1;
    do @(posedge clk); while (!sample_ready);
    samples_sent++;
  endtask

  task automatic idle_sender(input int cycles);
    if (cycles > 0) begin
      sample_valid <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  // Pause the sender until every sent sample has its result checked
  task automatic wait_drained();
    sample_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Mostly short gaps, a few long ones that land anywhere in a window pass
  function automatic int pick_gap(input bit idle_on);
    int r;
    r = $urandom_range(0, 99);
    if (!idle_on || rx_holding) return 0;
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 40);
    return $urandom_range(100, 300);
  endfunction

  function automatic int pick_stall();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 20);
    return $urandom_range(21, 40);
  endfunction

  function automatic logic signed [31:0] gen_sample(input sample_mode_t mode, input int t,
                                                    input int amp);
    int pos;
    int ramp;
    pos  = t % WIN_LEN;
    ramp = (pos < WIN_LEN / 2) ? pos - WIN_LEN / 4 : 3 * WIN_LEN / 4 - pos;
    case (mode)
      MODE_FULL:  return $urandom;
      MODE_SMALL: return $urandom_range(0, 4096) - 2048;
      MODE_EXTREME: begin
        case ($urandom_range(0, 4))
          0:       return 32'sh7fffffff;
          1:       return 32'sh80000000;
          2:       return 32'sh00000000;
          3:       return 32'shffffffff;
          default: return 32'sh00000001;
        endcase
      end
      MODE_SQUARE: return (pos < WIN_LEN / 2) ? amp : -amp;
      default:     return ramp * amp;
    endcase
  endfunction

  // Sender: reset, directed corners, then segments of signal shapes and noise
  initial begin
    sample_mode_t mode;
    int           seg_left;
    int           amp;
    int           t;
    int           r;
    bit           idle_on;
    rst          <= 1'b1;
    sample_valid <= 1'b0;
    sample       <= '0;
    samples_sent = 0;
    seg_left     = 0;
    amp          = 0;
    t            = 0;
    idle_on      = 1'b0;
    mode         = MODE_FULL;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (DIRECTED[i]) begin
      send_sample(DIRECTED[i]);
      idle_sender((i % 4 == 3) ? 2 : 0);
    end
    wait_drained();

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (seg_left == 0) begin
        r = $urandom_range(0, 9);
        if (r < 3) mode = MODE_FULL;
        else if (r < 5) mode = MODE_SMALL;
        else if (r < 6) mode = MODE_EXTREME;
        else if (r < 8) mode = MODE_SQUARE;
        else mode = MODE_RAMP;
        amp      = (mode == MODE_RAMP) ? $urandom_range(1, 40_000_000)
                                       : $urandom_range(1, 32'h7fffffff);
        seg_left = $urandom_range(20, 120);
        idle_on  = ($urandom_range(0, 3) != 0);
        t        = 0;
      end
      send_sample(gen_sample(mode, t, amp));
      t++;
      seg_left--;
      if (n % DRAIN_EVERY == DRAIN_EVERY - 1) wait_drained();
      else idle_sender(pick_gap(idle_on));
    end

    // Drop valid, wait for the last results, then watch for strays
    wait_drained();
    repeat (WIN_LEN + 20) @(posedge clk);
    $display("Run covered %0d samples and %0d checked phasors over a %0d-tap window,",
             samples_sent, results_checked, WIN_LEN);
    $display("mixing full-scale noise, corners, square and ramp signals, a hold-off and drains.");
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Receiver: random ready windows and stalls, one long hold-off to back up the block
  initial begin
    int  rx_cycles;
    int  on_len;
    int  off_len;
    bit  hold_done;
    rx_cycles  = 0;
    hold_done  = 1'b0;
    result_ready <= 1'b0;
    rx_holding   <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (!hold_done && rx_cycles >= HOLD_START) begin
        hold_done = 1'b1;
        result_ready <= 1'b0;
        rx_holding   <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_cycles  += HOLD_CYCLES;
        rx_holding <= 1'b0;
      end
      result_ready <= 1'b1;
      on_len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : $urandom_range(5, 60);
      repeat (on_len) @(posedge clk);
      rx_cycles += on_len;
      off_len = pick_stall();
      if (off_len > 0) begin
        result_ready <= 1'b0;
        repeat (off_len) @(posedge clk);
        rx_cycles += off_len;
      end
    end
  end

  // Bound the run in case the block hangs
  initial begin
    #(LIMIT_CYCLES * CLK_PERIOD);
    $display("timeout after %0d cycles with %0d results pending", LIMIT_CYCLES, pending);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
